// ----- hw/rtl/mfmd_pkg.sv -----
`timescale 1ns / 1ps

package mfmd_pkg;

  // Scale factors, each rounded to 32 fraction bits.
  localparam logic signed [29:0] K_TENTH   = 30'sd429496730;  // 0.1
  localparam logic signed [29:0] K_RPM2RAD = 30'sd449767923;  // pi/30
  localparam logic signed [20:0] K_CNT2RAD = 21'sd823550;     // 2*pi/32768

  // A position step larger than half a turn counts as a wrap.
  localparam logic signed [16:0] JUMP_LIMIT = 17'sd16384;

  // Limits for the angle path.
  localparam logic signed [41:0] POS_CLAMP = 42'sd1099511627776;
  localparam logic signed [41:0] RAD_MAX   = 42'sd2199023255551;
  localparam logic signed [41:0] RAD_MIN   = -42'sd2199023255552;

  // Values handed from the decode stage to the scale stage.
  typedef struct packed {
    logic signed [15:0] speed_raw;
    logic signed [15:0] current_raw;
    logic signed [15:0] voltage_raw;
    logic signed [23:0] turn_count;
    logic signed [38:0] multi_turn_position;
    logic signed [41:0] clamped;
    logic signed [28:0] v16;
  } mfmd_mid_t;

endpackage

// ----- hw/rtl/motor_feedback_multiturn_decoder_unit.sv -----
`timescale 1ns / 1ps
// Motor feedback decoder with multi-turn position tracking.
// Input channel: one 8-byte feedback payload per beat on frame_payload,
// accepted at a clock edge with in_valid high and in_stall low. The payload
// holds speed, current, rotor position and voltage as big-endian words.
// Output channel: one result beat per input beat, with the raw words, the
// turn count, the multi-turn position and the velocity and angle in Q.16.
// It is taken at an edge with out_valid high and out_stall low.
// The position offset is written through cfg_write_en / cfg_write_data,
// only while no beat is in flight: a rule for the user, not enforced here.
// The path holds a decode stage register, then the result register after the
// scaling multipliers. One beat is taken every cycle while no stall holds.
// When the receiver stalls, the whole two-stage pipeline holds and in_stall
// rises in the same cycle; nothing is dropped.
// A synchronous reset clears the turn counter, the stored previous position,
// the offset and both stage valid flags. The first beat after reset is
// compared against a previous position of zero.
module motor_feedback_multiturn_decoder_unit import mfmd_pkg::*; #(
  parameter int TURN_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        frame_payload,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] speed_raw,
  output logic signed [15:0] current_raw,
  output logic signed [15:0] voltage_raw,
  output logic signed [23:0] turn_count,
  output logic signed [38:0] multi_turn_position,
  output logic signed [25:0] velocity_rad,
  output logic signed [41:0] position_rad,
  input  logic               cfg_write_en,
  input  logic [31:0]        cfg_write_data
);

  logic               advance;
  logic               accept;
  logic               mid_valid;
  logic signed [31:0] position_offset;
  mfmd_mid_t          mid;

  // The pipeline moves whenever the result register is free or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      mid_valid <= in_valid;
      out_valid <= mid_valid;
    end
  end

  // Position offset register.
  always_ff @(posedge clk) begin
    if (rst) begin
      position_offset <= '0;
    end else if (cfg_write_en) begin
      position_offset <= $signed(cfg_write_data);
    end
  end

  mfmd_decode #(
    .TURN_BITS (TURN_BITS)
  ) u_decode (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .advance       (advance),
    .frame_payload (frame_payload),
    .mid           (mid)
  );

  mfmd_scale u_scale (
    .clk                 (clk),
    .advance             (advance),
    .mid                 (mid),
    .position_offset     (position_offset),
    .speed_raw           (speed_raw),
    .current_raw         (current_raw),
    .voltage_raw         (voltage_raw),
    .turn_count          (turn_count),
    .multi_turn_position (multi_turn_position),
    .velocity_rad        (velocity_rad),
    .position_rad        (position_rad)
  );

endmodule

// ----- hw/rtl/mfmd_decode.sv -----
`timescale 1ns / 1ps

module mfmd_decode import mfmd_pkg::*; #(
  parameter int TURN_BITS = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             advance,
  input  logic [63:0]      frame_payload,
  output mfmd_mid_t        mid
);

  localparam int FULL_W = TURN_BITS + 16;
  localparam int CMP_W  = (FULL_W > 42) ? FULL_W : 42;
  localparam int TCW    = (TURN_BITS > 24) ? TURN_BITS : 24;

  logic [TURN_BITS-1:0] turns;
  logic [TURN_BITS-1:0] turns_next;
  logic [15:0]          previous_position;

  logic signed [15:0]       speed;
  logic signed [15:0]       current;
  logic signed [15:0]       pos;
  logic signed [15:0]       volt;
  logic signed [16:0]       diff;
  logic signed [CMP_W-1:0]  turns_ext;
  logic signed [CMP_W-1:0]  full;
  logic signed [CMP_W-1:0]  clamp_val;
  logic signed [TCW-1:0]    tc_ext;
  logic signed [45:0]       sp_prod;
  logic signed [45:0]       sp_bias;
  logic signed [45:0]       sp_round;
  mfmd_mid_t                mid_next;

  // Split the payload into its four big-endian words.
  assign speed   = $signed(frame_payload[63:48]);
  assign current = $signed(frame_payload[47:32]);
  assign pos     = $signed(frame_payload[31:16]);
  assign volt    = $signed(frame_payload[15:0]);

  // Turn tracking: a large step in either direction is a wrap of the rotor.
  always_comb begin
    diff = 17'(pos) - 17'($signed(previous_position));
    if (diff > JUMP_LIMIT) begin
      turns_next = turns - 1'b1;
    end else if (diff < -JUMP_LIMIT) begin
      turns_next = turns + 1'b1;
    end else begin
      turns_next = turns;
    end
  end

  // Multi-turn position, widened so the clamp compare sees the true value.
  always_comb begin
    turns_ext = CMP_W'($signed(turns_next));
    full      = (turns_ext <<< 15) + CMP_W'(pos);
    tc_ext    = TCW'($signed(turns_next));
    if (full > CMP_W'(POS_CLAMP)) begin
      clamp_val = CMP_W'(POS_CLAMP);
    end else if (full < -CMP_W'(POS_CLAMP)) begin
      clamp_val = -CMP_W'(POS_CLAMP);
    end else begin
      clamp_val = full;
    end
  end

  // Speed to rpm in Q.16, rounded to nearest with ties away from zero.
  always_comb begin
    sp_prod  = 46'(speed) * 46'(K_TENTH);
    sp_bias  = sp_prod[45] ? 46'sd32767 : 46'sd32768;
    sp_round = sp_prod + sp_bias;
  end

  always_comb begin
    mid_next.speed_raw           = speed;
    mid_next.current_raw         = current;
    mid_next.voltage_raw         = volt;
    mid_next.turn_count          = tc_ext[23:0];
    mid_next.multi_turn_position = full[38:0];
    mid_next.clamped             = clamp_val[41:0];
    mid_next.v16                 = 29'(sp_round >>> 16);
  end

  // Tracker state moves only when a beat is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      turns             <= '0;
      previous_position <= '0;
    end else if (accept) begin
      turns             <= turns_next;
      previous_position <= frame_payload[31:16];
    end
  end

  // Stage register toward the scale stage.
  always_ff @(posedge clk) begin
    if (advance) begin
      mid <= mid_next;
    end
  end

  // The turn counter changes only on an accepted beat.
  a_turns_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(turns))
    else $error("turn counter changed without an accepted beat");

  // One beat moves the counter by at most one turn.
  a_turns_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (turns == $past(turns) || turns == $past(turns) - 1'b1 ||
                turns == $past(turns) + 1'b1))
    else $error("turn counter stepped by more than one");

  // The stored position follows the accepted beat.
  a_prev_track: assert property (@(posedge clk) disable iff (rst)
    accept |=> previous_position == $past(frame_payload[31:16]))
    else $error("previous position not taken from the accepted beat");

endmodule

// ----- hw/rtl/mfmd_scale.sv -----
`timescale 1ns / 1ps

module mfmd_scale import mfmd_pkg::*; (
  input  logic               clk,
  input  logic               advance,
  input  mfmd_mid_t          mid,
  input  logic signed [31:0] position_offset,
  output logic signed [15:0] speed_raw,
  output logic signed [15:0] current_raw,
  output logic signed [15:0] voltage_raw,
  output logic signed [23:0] turn_count,
  output logic signed [38:0] multi_turn_position,
  output logic signed [25:0] velocity_rad,
  output logic signed [41:0] position_rad
);

  logic signed [58:0] vel_prod;
  logic signed [58:0] vel_bias;
  logic signed [25:0] vel;
  logic signed [62:0] pos_prod;
  logic signed [62:0] pos_bias;
  logic signed [46:0] rad;
  logic signed [47:0] ang;
  logic signed [41:0] ang_sat;

  // Velocity in rad/s, Q.16, rounded with ties away from zero.
  always_comb begin
    vel_prod = 59'($signed(mid.v16)) * 59'(K_RPM2RAD);
    vel_bias = vel_prod[58] ? 59'sd2147483647 : 59'sd2147483648;
    vel      = 26'((vel_prod + vel_bias) >>> 32);
  end

  // Angle in rad, Q.16, then the zero-point offset and saturation.
  always_comb begin
    pos_prod = 63'($signed(mid.clamped)) * 63'(K_CNT2RAD);
    pos_bias = pos_prod[62] ? 63'sd32767 : 63'sd32768;
    rad      = 47'((pos_prod + pos_bias) >>> 16);
    ang      = 48'sd0 - 48'(rad) - 48'(position_offset);
    if (ang > 48'(RAD_MAX)) begin
      ang_sat = RAD_MAX;
    end else if (ang < 48'(RAD_MIN)) begin
      ang_sat = RAD_MIN;
    end else begin
      ang_sat = ang[41:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      speed_raw           <= mid.speed_raw;
      current_raw         <= mid.current_raw;
      voltage_raw         <= mid.voltage_raw;
      turn_count          <= mid.turn_count;
      multi_turn_position <= mid.multi_turn_position;
      velocity_rad        <= -vel;
      position_rad        <= ang_sat;
    end
  end

endmodule
